FILE: rtl/lbfgs_de_pkg.sv
// shared constants and saturating arithmetic helpers for the l-bfgs direction engine
package lbfgs_de_pkg;

    localparam int NUM_PARAMS_DEF  = 32;
    localparam int MAX_HISTORY_DEF = 8;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PARAMS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURV_THRESH   = 2'd1;

    localparam logic [5:0]  ACTIVE_RESET = 6'd32;
    localparam logic [15:0] THRESH_RESET = 16'd1;

    localparam logic signed [31:0] ONE_Q   = 32'sh0100_0000;
    localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

    localparam int unsigned DIV_BITS = 56;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7fff_ffff) r = Q_MAX;
        else if (x < -64'sh0000_0000_8000_0000) r = Q_MIN;
        else r = x[31:0];
        return r;
    endfunction

    // saturating 64-bit accumulate of a 40-bit scaled product
    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [39:0] p);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} + {{25{p[39]}}, p};
        if (s[64] != s[63]) r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else r = s[63:0];
        return r;
    endfunction

endpackage

FILE: rtl/lbfgs_direction_engine.sv
// l-bfgs direction engine: update staging, history ring and two-loop recursion sequencer
//
// Input stream (s_axis_*): tuser = opcode (0 update pair, 1 gradient), tlast ends the
// vector, tdata = value_a (bits 31:0), value_b (bits 63:32). One item is taken per
// visit to idle; s_axis_tready is low while the sequencer works.
// Output stream (m_axis_*): tuser = result kind (0 status, 1 direction element),
// tlast marks the last result of a run. A result waits in the output register;
// while the receiver stalls the sequencer holds before loading the next one.
// Config port: cfg index 0 = active_params, 1 = curvature_threshold; always ready.
// A final update whose dot product exceeds the threshold runs the bit-serial 1/dot
// divider and copies the staged pair into the ring. A final gradient pads the vector,
// runs the two-loop recursion when history exists (gamma on the same divider) and emits
// the direction. All products come from the single shared 32x32 multiplier.
// Reset clears ring head, history count, element counter, accumulator, the
// configuration registers and the output register; history memories are not cleared.
module lbfgs_direction_engine #(
    parameter int NUM_PARAMS  = lbfgs_de_pkg::NUM_PARAMS_DEF,
    parameter int MAX_HISTORY = lbfgs_de_pkg::MAX_HISTORY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value_a [31:0], value_b [63:32]
    input  logic        s_axis_tuser,   // opcode
    input  logic        s_axis_tlast,   // last_element
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // direction_value [31:0], element_index [36:32],
                                        // update_accepted [37], zero [39:38]
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast,   // last_result
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [lbfgs_de_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int LIM   = (NUM_PARAMS < 32) ? NUM_PARAMS : 32;
    localparam int NW    = $clog2(LIM + 1);
    localparam int IW    = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam int CLW   = $clog2(MAX_HISTORY + 1);
    localparam int DEPTH = (MAX_HISTORY + 1) * NUM_PARAMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int DCW   = $clog2(lbfgs_de_pkg::DIV_BITS);

    typedef enum logic [4:0] {
        S_IDLE, S_UPD_MUL, S_UPD_ACC, S_UPD_CHK, S_DIV, S_DIV_END,
        S_COPY_RD, S_COPY_WR, S_STATUS, S_FILL, S_PASS_RD, S_PASS_MUL,
        S_PASS_WB, S_NEXT, S_SCL_MUL, S_SCL_WB, S_EMIT_RD, S_EMIT_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_L1_DOT, PH_L1_AXPY, PH_SY, PH_YY, PH_SCALE, PH_L2_DOT, PH_L2_AXPY
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [5:0]             r_active;
    logic [15:0]            r_thresh;
    logic [NW-1:0]          r_cnt;
    logic                   r_kind;
    logic signed [63:0]     r_acc;
    logic [CLW-1:0]         r_head, r_count, r_col, r_iter;
    logic [NW-1:0]          r_j;
    logic signed [31:0]     r_ina, r_inb, r_coef, r_sy;
    logic                   r_last, r_ok;
    logic signed [63:0]     r_prod;
    logic signed [31:0]     r_sd, r_yd, r_wd;
    logic signed [31:0]     r_rho   [MAX_HISTORY+1];
    logic signed [31:0]     r_alpha [MAX_HISTORY+1];
    logic [63:0]            r_rem, r_dvs;
    logic [lbfgs_de_pkg::DIV_BITS-1:0] r_quo;
    logic [DCW-1:0]         r_dcnt;
    logic                   r_dneg, r_div_gamma;

    logic                   r_m_valid, r_m_kind, r_m_last, r_m_ok;
    logic signed [31:0]     r_m_dir;
    logic [4:0]             r_m_idx;

    logic signed [31:0]     s_mem [DEPTH];
    logic signed [31:0]     y_mem [DEPTH];
    logic signed [31:0]     w_mem [NUM_PARAMS];

    logic [NW-1:0]          w_n;
    logic                   w_accept, w_ofree, w_took, w_gt_thr, w_m_load;
    logic [NW-1:0]          w_eff_cnt;
    logic signed [63:0]     w_eff_acc;
    logic [AW-1:0]          w_rd_addr, w_h_addr;
    logic                   w_h_we, w_w_we;
    logic signed [31:0]     w_h_sd, w_h_yd, w_w_d;
    logic [IW-1:0]          w_w_addr;
    logic signed [31:0]     w_ma, w_mb;
    logic signed [39:0]     w_fl;
    logic signed [31:0]     w_fl_sat, w_acc_sat, w_wb_val;
    logic [CLW-1:0]         w_prev_col, w_next_col, w_newest, w_oldest, w_head_nx;
    logic [64:0]            w_rem_sh;
    logic signed [31:0]     w_div_res;
    logic [31:0]            w_sy_mag;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_ofree       = !r_m_valid || m_axis_tready;
    // the sequencer loads a new result into the output register this cycle
    assign w_m_load      = w_ofree && (r_state == S_STATUS || r_state == S_EMIT_OUT);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = {2'b00, r_m_ok, r_m_idx, r_m_dir};

    always_comb begin
        if (r_active == 6'd0) w_n = NW'(1);
        else if ({1'b0, r_active} > 7'(LIM)) w_n = NW'(LIM);
        else w_n = NW'(r_active);
    end

    // a stream of the other kind drops the partial one
    assign w_eff_cnt = (r_cnt != '0 && s_axis_tuser != r_kind) ? '0 : r_cnt;
    assign w_eff_acc = (r_cnt != '0 && s_axis_tuser != r_kind) ? '0 : r_acc;
    assign w_took    = w_eff_cnt < w_n;
    assign w_gt_thr  = r_acc > $signed({48'd0, r_thresh});

    assign w_rd_addr = AW'(r_col) * AW'(NUM_PARAMS) + AW'(r_j);
    assign w_prev_col = (r_col == '0) ? CLW'(MAX_HISTORY - 1) : r_col - CLW'(1);
    assign w_next_col = (r_col == CLW'(MAX_HISTORY - 1)) ? '0 : r_col + CLW'(1);
    assign w_newest   = (r_head == '0) ? CLW'(MAX_HISTORY - 1) : r_head - CLW'(1);
    assign w_head_nx  = (r_head == CLW'(MAX_HISTORY - 1)) ? '0 : r_head + CLW'(1);
    assign w_oldest   = (r_head >= r_count) ? r_head - r_count
                                            : r_head + CLW'(MAX_HISTORY) - r_count;

    assign w_fl      = r_prod[63:24];
    assign w_fl_sat  = lbfgs_de_pkg::sat32({{24{w_fl[39]}}, w_fl});
    assign w_acc_sat = lbfgs_de_pkg::sat32(r_acc);
    assign w_sy_mag  = r_sy[31] ? 32'(-{r_sy[31], r_sy}) : 32'(r_sy);

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_UPD_MUL: begin w_ma = r_ina; w_mb = r_inb; end
            S_SCL_MUL: begin w_ma = r_rho[r_col]; w_mb = w_acc_sat; end
            S_PASS_MUL: begin
                case (r_phase)
                    PH_L1_DOT:  begin w_ma = r_sd;   w_mb = r_wd;   end
                    PH_L1_AXPY: begin w_ma = r_coef; w_mb = r_yd;   end
                    PH_SY:      begin w_ma = r_sd;   w_mb = r_yd;   end
                    PH_YY:      begin w_ma = r_yd;   w_mb = r_yd;   end
                    PH_SCALE:   begin w_ma = r_coef; w_mb = r_wd;   end
                    PH_L2_DOT:  begin w_ma = r_yd;   w_mb = r_wd;   end
                    PH_L2_AXPY: begin w_ma = r_sd;   w_mb = r_coef; end
                    default:    begin w_ma = '0;     w_mb = '0;     end
                endcase
            end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    always_comb begin
        case (r_phase)
            PH_L1_AXPY: w_wb_val = lbfgs_de_pkg::sat32(64'(r_wd) - 64'(w_fl));
            PH_L2_AXPY: w_wb_val = lbfgs_de_pkg::sat32(64'(r_wd) + 64'(w_fl));
            default:    w_wb_val = w_fl_sat;
        endcase
    end

    assign w_rem_sh = {r_rem, r_quo[lbfgs_de_pkg::DIV_BITS-1]};

    always_comb begin
        if (r_dneg) begin
            if (r_quo > lbfgs_de_pkg::DIV_BITS'(64'h8000_0000)) w_div_res = lbfgs_de_pkg::Q_MIN;
            else w_div_res = 32'(-r_quo);
        end else begin
            if (r_quo > lbfgs_de_pkg::DIV_BITS'(64'h7fff_ffff)) w_div_res = lbfgs_de_pkg::Q_MAX;
            else w_div_res = 32'(r_quo);
        end
    end

    // history and work vector write ports
    always_comb begin
        w_h_we = 1'b0;
        w_h_addr = AW'(r_head) * AW'(NUM_PARAMS) + AW'(r_j);
        w_h_sd = (r_j < r_cnt) ? r_sd : '0;
        w_h_yd = (r_j < r_cnt) ? r_yd : '0;
        if (r_state == S_IDLE) begin
            w_h_we   = w_accept && !s_axis_tuser && w_took;
            w_h_addr = AW'(MAX_HISTORY * NUM_PARAMS) + AW'(w_eff_cnt);
            w_h_sd   = s_axis_tdata[31:0];
            w_h_yd   = s_axis_tdata[63:32];
        end else if (r_state == S_COPY_WR) begin
            w_h_we = 1'b1;
        end
    end

    always_comb begin
        w_w_we   = 1'b0;
        w_w_addr = r_j[IW-1:0];
        w_w_d    = w_wb_val;
        case (r_state)
            S_IDLE: begin
                w_w_we   = w_accept && s_axis_tuser && w_took;
                w_w_addr = w_eff_cnt[IW-1:0];
                w_w_d    = s_axis_tdata[31:0];
            end
            S_FILL: begin
                w_w_we = (r_j < w_n);
                w_w_d  = '0;
            end
            S_PASS_WB: w_w_we = (r_phase == PH_L1_AXPY || r_phase == PH_SCALE ||
                                 r_phase == PH_L2_AXPY);
            default: w_w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_h_we) begin
            s_mem[w_h_addr] <= w_h_sd;
            y_mem[w_h_addr] <= w_h_yd;
        end
        if (w_w_we) w_mem[w_w_addr] <= w_w_d;
        r_sd <= s_mem[w_rd_addr];
        r_yd <= y_mem[w_rd_addr];
        r_wd <= w_mem[r_j[IW-1:0]];
        r_prod <= w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_L1_DOT;
            r_active  <= lbfgs_de_pkg::ACTIVE_RESET;
            r_thresh  <= lbfgs_de_pkg::THRESH_RESET;
            r_cnt     <= '0;
            r_kind    <= 1'b0;
            r_acc     <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lbfgs_de_pkg::CFG_ACTIVE_PARAMS: r_active <= i_cfg_data[5:0];
                    lbfgs_de_pkg::CFG_CURV_THRESH:   r_thresh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_m_valid && m_axis_tready && !w_m_load) r_m_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind <= s_axis_tuser;
                        r_cnt  <= w_took ? w_eff_cnt + NW'(1) : w_eff_cnt;
                        r_acc  <= w_eff_acc;
                        r_ina  <= s_axis_tdata[31:0];
                        r_inb  <= s_axis_tdata[63:32];
                        r_last <= s_axis_tlast;
                        r_j    <= w_took ? w_eff_cnt + NW'(1) : w_eff_cnt;
                        if (!s_axis_tuser) begin
                            if (w_took) r_state <= S_UPD_MUL;
                            else if (s_axis_tlast) r_state <= S_UPD_CHK;
                        end else if (s_axis_tlast) begin
                            r_state <= S_FILL;
                        end
                    end
                end
                S_UPD_MUL: r_state <= S_UPD_ACC;
                S_UPD_ACC: begin
                    r_acc   <= lbfgs_de_pkg::sadd64(r_acc, w_fl);
                    r_state <= r_last ? S_UPD_CHK : S_IDLE;
                end
                S_UPD_CHK: begin
                    if (w_gt_thr) begin
                        r_rem       <= '0;
                        r_quo       <= lbfgs_de_pkg::DIV_BITS'(64'h0001_0000_0000_0000);
                        r_dvs       <= r_acc;
                        r_dneg      <= 1'b0;
                        r_div_gamma <= 1'b0;
                        r_dcnt      <= DCW'(lbfgs_de_pkg::DIV_BITS - 1);
                        r_state     <= S_DIV;
                    end else begin
                        r_ok    <= 1'b0;
                        r_state <= S_STATUS;
                    end
                end
                S_DIV: begin
                    // restoring divider, one quotient bit per cycle
                    if (w_rem_sh >= {1'b0, r_dvs}) begin
                        r_rem <= 64'(w_rem_sh - {1'b0, r_dvs});
                        r_quo <= {r_quo[lbfgs_de_pkg::DIV_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh[63:0];
                        r_quo <= {r_quo[lbfgs_de_pkg::DIV_BITS-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == '0) r_state <= S_DIV_END;
                end
                S_DIV_END: begin
                    r_j   <= '0;
                    r_acc <= '0;
                    if (r_div_gamma) begin
                        r_coef  <= w_div_res;
                        r_phase <= PH_SCALE;
                        r_state <= S_PASS_RD;
                    end else begin
                        r_rho[r_head] <= w_div_res;
                        r_col   <= CLW'(MAX_HISTORY);
                        r_state <= S_COPY_RD;
                    end
                end
                S_COPY_RD: r_state <= S_COPY_WR;
                S_COPY_WR: begin
                    if (r_j == w_n - NW'(1)) begin
                        r_head  <= w_head_nx;
                        if (r_count != CLW'(MAX_HISTORY)) r_count <= r_count + CLW'(1);
                        r_ok    <= 1'b1;
                        r_state <= S_STATUS;
                    end else begin
                        r_j     <= r_j + NW'(1);
                        r_state <= S_COPY_RD;
                    end
                end
                S_STATUS: begin
                    if (w_ofree) begin
                        r_m_valid <= 1'b1;
                        r_m_kind  <= 1'b0;
                        r_m_dir   <= '0;
                        r_m_idx   <= '0;
                        r_m_ok    <= r_ok;
                        r_m_last  <= 1'b1;
                        r_cnt     <= '0;
                        r_acc     <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                S_FILL: begin
                    if (r_j < w_n) begin
                        r_j <= r_j + NW'(1);
                    end else begin
                        r_j   <= '0;
                        r_acc <= '0;
                        if (r_count == '0) begin
                            r_state <= S_EMIT_RD;
                        end else begin
                            r_col   <= w_newest;
                            r_iter  <= '0;
                            r_phase <= PH_L1_DOT;
                            r_state <= S_PASS_RD;
                        end
                    end
                end
                S_PASS_RD:  r_state <= S_PASS_MUL;
                S_PASS_MUL: r_state <= S_PASS_WB;
                S_PASS_WB: begin
                    case (r_phase) inside
                        PH_L1_DOT, PH_SY, PH_YY, PH_L2_DOT:
                            r_acc <= lbfgs_de_pkg::sadd64(r_acc, w_fl);
                        default: ;
                    endcase
                    if (r_j == w_n - NW'(1)) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_j     <= r_j + NW'(1);
                        r_state <= S_PASS_RD;
                    end
                end
                S_NEXT: begin
                    r_j   <= '0;
                    unique case (r_phase)
                        // dot passes keep the sum for the scaling multiply
                        PH_L1_DOT, PH_L2_DOT: begin
                            r_state <= S_SCL_MUL;
                        end
                        PH_L1_AXPY: begin
                            r_acc   <= '0;
                            r_state <= S_PASS_RD;
                            if (r_iter + CLW'(1) < r_count) begin
                                r_iter  <= r_iter + CLW'(1);
                                r_col   <= w_prev_col;
                                r_phase <= PH_L1_DOT;
                            end else begin
                                r_col   <= w_newest;
                                r_phase <= PH_SY;
                            end
                        end
                        PH_SY: begin
                            r_acc   <= '0;
                            r_sy    <= w_acc_sat;
                            r_phase <= PH_YY;
                            r_state <= S_PASS_RD;
                        end
                        PH_YY: begin
                            r_acc <= '0;
                            if (r_acc > 64'sd0) begin
                                r_rem       <= '0;
                                r_quo       <= {w_sy_mag, 24'd0};
                                r_dvs       <= r_acc;
                                r_dneg      <= r_sy[31];
                                r_div_gamma <= 1'b1;
                                r_dcnt      <= DCW'(lbfgs_de_pkg::DIV_BITS - 1);
                                r_state     <= S_DIV;
                            end else begin
                                r_coef  <= lbfgs_de_pkg::ONE_Q;
                                r_phase <= PH_SCALE;
                                r_state <= S_PASS_RD;
                            end
                        end
                        PH_SCALE: begin
                            r_acc   <= '0;
                            r_iter  <= '0;
                            r_col   <= w_oldest;
                            r_phase <= PH_L2_DOT;
                            r_state <= S_PASS_RD;
                        end
                        PH_L2_AXPY: begin
                            r_acc <= '0;
                            if (r_iter + CLW'(1) < r_count) begin
                                r_iter  <= r_iter + CLW'(1);
                                r_col   <= w_next_col;
                                r_phase <= PH_L2_DOT;
                                r_state <= S_PASS_RD;
                            end else begin
                                r_state <= S_EMIT_RD;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_SCL_MUL: r_state <= S_SCL_WB;
                S_SCL_WB: begin
                    r_j   <= '0;
                    r_acc <= '0;
                    if (r_phase == PH_L1_DOT) begin
                        r_alpha[r_col] <= w_fl_sat;
                        r_coef  <= w_fl_sat;
                        r_phase <= PH_L1_AXPY;
                    end else begin
                        r_coef  <= lbfgs_de_pkg::sat32(64'(r_alpha[r_col]) - 64'(w_fl_sat));
                        r_phase <= PH_L2_AXPY;
                    end
                    r_state <= S_PASS_RD;
                end
                S_EMIT_RD: r_state <= S_EMIT_OUT;
                S_EMIT_OUT: begin
                    if (w_ofree) begin
                        r_m_valid <= 1'b1;
                        r_m_kind  <= 1'b1;
                        r_m_dir   <= lbfgs_de_pkg::sat32(-64'(r_wd));
                        r_m_idx   <= 5'(r_j);
                        r_m_ok    <= 1'b0;
                        r_m_last  <= (r_j == w_n - NW'(1));
                        if (r_j == w_n - NW'(1)) begin
                            r_cnt   <= '0;
                            r_acc   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + NW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CLW'(MAX_HISTORY))
        else $error("history count above ring depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < CLW'(MAX_HISTORY))
        else $error("ring head out of range");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_kind) |-> (r_m_last && r_m_dir == '0 && r_m_idx == '0))
        else $error("status item carries direction data");

    a_pass_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS_WB || r_state == S_EMIT_OUT) |-> (r_j < w_n))
        else $error("element index beyond vector length");

    a_recursion_needs_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCL_MUL) |-> (r_count != '0))
        else $error("recursion pass with empty history");

endmodule

FILE: test/lbfgs_direction_engine_check.sv
// checker for the l-bfgs direction engine: tracks inputs, predicts results, compares outputs
module lbfgs_direction_engine_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,
    input  logic        i_in_user,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,
    input  logic        i_out_user,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [lbfgs_de_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_UPDATE   = 1'b0;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DIR    = 1'b1;
    localparam int   HIST        = 8;
    localparam int   STAGE       = 8;
    localparam longint LMAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint LMIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic              kind;
        logic signed [31:0] dir;
        logic [4:0]        idx;
        logic              acc;
        logic              last;
    } t_engine_result;

    t_engine_result result_q[$];

    int s_col[9][32];
    int y_col[9][32];
    int rho[9];
    int alpha[8];
    int work[32];
    int unsigned head, hcount, elem_cnt;
    longint dot_acc;
    logic stream_op;
    logic [5:0] len_reg;
    logic [15:0] thresh_reg;

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        if (b > 0 && a > LMAX - b) return LMAX;
        if (b < 0 && a < LMIN - b) return LMIN;
        return a + b;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 24;
    endfunction

    function automatic longint vec_dot(int u[32], int v[32], int unsigned n);
        longint acc;
        acc = 0;
        for (int j = 0; j < n; j++) acc = add_sat(acc, qmul(u[j], v[j]));
        return acc;
    endfunction

    function automatic int unsigned vec_len();
        int unsigned n;
        n = len_reg;
        if (n == 0) n = 1;
        if (n > 32) n = 32;
        return n;
    endfunction

    task automatic close_update(int unsigned n);
        t_engine_result r;
        logic ok;
        for (int unsigned j = elem_cnt; j < n; j++) begin
            s_col[STAGE][j] = 0;
            y_col[STAGE][j] = 0;
        end
        ok = (dot_acc > longint'(thresh_reg));
        if (ok) begin
            rho[head] = int'(clip32((longint'(1) << 48) / dot_acc));
            for (int j = 0; j < n; j++) begin
                s_col[head][j] = s_col[STAGE][j];
                y_col[head][j] = y_col[STAGE][j];
            end
            head = (head + 1) % HIST;
            if (hcount < HIST) hcount++;
        end
        r = '{KIND_STATUS, 32'sd0, 5'd0, ok, 1'b1};
        result_q.push_back(r);
    endtask

    // two-loop recursion on the work vector, then emit the negated direction
    task automatic close_gradient(int unsigned n);
        t_engine_result r;
        int unsigned c, newest;
        longint sy, yy, gamma, beta, diff;
        for (int unsigned j = elem_cnt; j < n; j++) work[j] = 0;
        if (hcount > 0) begin
            for (int unsigned i = 0; i < hcount; i++) begin
                c = (head + HIST - 1 - i) % HIST;
                alpha[c] = int'(clip32(qmul(rho[c], clip32(vec_dot(s_col[c], work, n)))));
                for (int j = 0; j < n; j++)
                    work[j] = int'(clip32(longint'(work[j]) - qmul(alpha[c], y_col[c][j])));
            end
            newest = (head + HIST - 1) % HIST;
            sy = vec_dot(s_col[newest], y_col[newest], n);
            yy = vec_dot(y_col[newest], y_col[newest], n);
            gamma = (yy > 0) ? clip32((clip32(sy) * longint'(lbfgs_de_pkg::ONE_Q)) / yy)
                             : longint'(lbfgs_de_pkg::ONE_Q);
            for (int j = 0; j < n; j++) work[j] = int'(clip32(qmul(gamma, work[j])));
            for (int unsigned i = 0; i < hcount; i++) begin
                c = (head + HIST - hcount + i) % HIST;
                beta = clip32(qmul(rho[c], clip32(vec_dot(y_col[c], work, n))));
                diff = clip32(longint'(alpha[c]) - beta);
                for (int j = 0; j < n; j++)
                    work[j] = int'(clip32(longint'(work[j]) + qmul(s_col[c][j], diff)));
            end
        end
        for (int unsigned j = 0; j < n; j++) begin
            r.kind = KIND_DIR;
            r.dir  = 32'(clip32(-longint'(work[j])));
            r.idx  = 5'(j);
            r.acc  = 1'b0;
            r.last = (j == n - 1);
            result_q.push_back(r);
        end
    endtask

    task automatic take_item(logic op, longint a, longint b, logic last);
        int unsigned n;
        n = vec_len();
        if (elem_cnt > 0 && op != stream_op) begin
            elem_cnt = 0;
            dot_acc = 0;
        end
        stream_op = op;
        if (elem_cnt < n) begin
            if (op == OP_UPDATE) begin
                s_col[STAGE][elem_cnt] = int'(a);
                y_col[STAGE][elem_cnt] = int'(b);
                dot_acc = add_sat(dot_acc, qmul(a, b));
            end else begin
                work[elem_cnt] = int'(a);
            end
            elem_cnt++;
        end
        if (last) begin
            if (op == OP_UPDATE) close_update(n);
            else close_gradient(n);
            elem_cnt = 0;
            dot_acc = 0;
        end
    endtask

    task automatic check_result();
        t_engine_result exp_r, got;
        got = '{i_out_user, i_out_data[31:0], i_out_data[36:32], i_out_data[37], i_out_last};
        if (result_q.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, got);
            o_fail_count++;
        end else begin
            exp_r = result_q.pop_front();
            if (exp_r.kind != got.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
                o_fail_count++;
            end
            if (exp_r.dir != got.dir) begin
                $display("%0t: direction expected %0d actual %0d", $time, exp_r.dir, got.dir);
                o_fail_count++;
            end
            if (exp_r.idx != got.idx) begin
                $display("%0t: index expected %0d actual %0d", $time, exp_r.idx, got.idx);
                o_fail_count++;
            end
            if (exp_r.acc != got.acc) begin
                $display("%0t: accepted expected %0d actual %0d", $time, exp_r.acc, got.acc);
                o_fail_count++;
            end
            if (exp_r.last != got.last) begin
                $display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
                o_fail_count++;
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        head = 0;
        hcount = 0;
        elem_cnt = 0;
        dot_acc = 0;
        stream_op = OP_UPDATE;
        len_reg = lbfgs_de_pkg::ACTIVE_RESET;
        thresh_reg = lbfgs_de_pkg::THRESH_RESET;
        for (int c = 0; c < 9; c++) begin
            rho[c] = 0;
            for (int j = 0; j < 32; j++) begin
                s_col[c][j] = 0;
                y_col[c][j] = 0;
            end
        end
        for (int j = 0; j < 32; j++) work[j] = 0;
        for (int c = 0; c < 8; c++) alpha[c] = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == lbfgs_de_pkg::CFG_ACTIVE_PARAMS)
                    len_reg = i_cfg_data[5:0];
                else if (i_cfg_index == lbfgs_de_pkg::CFG_CURV_THRESH)
                    thresh_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                take_item(i_in_user, longint'($signed(i_in_data[31:0])),
                          longint'($signed(i_in_data[63:32])), i_in_last);
            if (i_out_valid && i_out_ready) check_result();
            o_pending = result_q.size();
        end
    end

endmodule

FILE: test/lbfgs_direction_engine_test.sv
// testbench top for the l-bfgs direction engine: stimulus, flow control and verdict
module lbfgs_direction_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_GRAD   = 1'b1;
    localparam logic [lbfgs_de_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [lbfgs_de_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;

    bit quiet = 0;
    bit calm = 0;
    bit hold_out = 0;
    int unsigned sent = 0;

    always #10 i_clk = ~i_clk;

    lbfgs_direction_engine u_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    lbfgs_direction_engine_check u_check (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_in_user(s_axis_tuser), .i_in_last(s_axis_tlast),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser), .i_out_last(m_axis_tlast),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    task automatic push(logic op, logic [31:0] a, logic [31:0] b, logic last);
        if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic send_vector(logic op, int unsigned len, bit zero_b, bit with_last);
        for (int unsigned j = 0; j < len; j++)
            push(op, rand_q(), zero_b ? 32'd0 : rand_q(), with_last && (j == len - 1));
    endtask

    // idle point: every expected result has come and the engine has settled
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [lbfgs_de_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int unsigned n, int unsigned target);
        int unsigned stop, r, len;
        logic op;
        stop = sent + target;
        while (sent < stop) begin
            r = $urandom_range(0, 9);
            op = $urandom_range(0, 1);
            calm = ($urandom_range(0, 3) == 0);
            if (r < 6) len = n;
            else if (r < 8) len = $urandom_range(1, n);
            else len = n + $urandom_range(1, 2);
            send_vector(op, len, (op == OP_UPDATE) && ($urandom_range(0, 7) == 0), r != 9);
        end
        calm = 0;
    endtask

    // receiver flow control, with one long hold-off on request
    initial begin
        forever begin
            if (hold_out) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_out = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full length via clamp, high threshold
        cfg_write(lbfgs_de_pkg::CFG_ACTIVE_PARAMS, 16'd63);
        cfg_write(lbfgs_de_pkg::CFG_CURV_THRESH, 16'hffff);
        cfg_write(CFG_UNUSED, 16'h1234);
        // empty history, short gradient with extremes
        push(OP_GRAD, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
        push(OP_GRAD, 32'h8000_0000, 32'h0, 1'b0);
        push(OP_GRAD, 32'h0, 32'h0, 1'b1);
        // tiny dot rejected, then unit pairs accepted
        push(OP_UPDATE, 32'h0000_0100, 32'h0000_0100, 1'b1);
        push(OP_UPDATE, 32'h0100_0000, 32'h0100_0000, 1'b0);
        push(OP_UPDATE, 32'h0100_0000, 32'h0100_0000, 1'b1);
        // negative curvature rejected
        push(OP_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
        // update dropped by an opcode switch
        push(OP_UPDATE, 32'h0300_0000, 32'h0200_0000, 1'b0);
        push(OP_GRAD, 32'h0080_0000, 32'h0, 1'b0);
        push(OP_GRAD, 32'hff00_0000, 32'h0, 1'b1);
        wait_idle();

        cfg_write(lbfgs_de_pkg::CFG_ACTIVE_PARAMS, 16'd8);
        cfg_write(lbfgs_de_pkg::CFG_CURV_THRESH, 16'($urandom_range(0, 65535)));
        random_phase(8, 50);
        hold_out = 1;
        send_vector(OP_GRAD, 8, 0, 1);
        send_vector(OP_GRAD, 8, 0, 1);
        random_phase(8, 50);
        wait_idle();

        cfg_write(lbfgs_de_pkg::CFG_ACTIVE_PARAMS, 16'd3);
        cfg_write(lbfgs_de_pkg::CFG_CURV_THRESH, 16'($urandom_range(0, 65535)));
        random_phase(3, 90);
        wait_idle();

        // single element, zero threshold, no idling from here on
        quiet = 1;
        cfg_write(lbfgs_de_pkg::CFG_ACTIVE_PARAMS, 16'd0);
        cfg_write(lbfgs_de_pkg::CFG_CURV_THRESH, 16'd0);
        push(OP_UPDATE, 32'd1, 32'd1, 1'b1);
        push(OP_UPDATE, 32'h0000_1000, 32'h0000_1000, 1'b1);
        push(OP_GRAD, 32'h0100_0000, 32'h0, 1'b0);
        push(OP_GRAD, 32'h7fff_ffff, 32'h0, 1'b0);
        push(OP_GRAD, 32'h8000_0000, 32'h0, 1'b1);
        push(OP_UPDATE, 32'h8000_0000, 32'h8000_0000, 1'b1);
        push(OP_GRAD, 32'h8000_0000, 32'h0, 1'b1);
        random_phase(1, 40);

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/lbfgs_de_pkg.sv
rtl/lbfgs_direction_engine.sv
test/lbfgs_direction_engine_check.sv
test/lbfgs_direction_engine_test.sv
